// ===== src/edc_pkg.sv =====
// Shared constants, widths and a helper function of the EWMA correlation block.
package edc_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int MOM_W       = 48;
    localparam int MOM_FRAC    = 46;
    localparam int PROD_W      = 2 * SAMPLE_BITS;
    localparam int BLEND_W     = MOM_W + 18;
    localparam int ROOT_W      = MOM_W - 1;
    localparam int RAD_W       = 2 * ROOT_W;
    localparam int QUO_W       = 17;
    localparam int CNT_W       = $clog2(((SAMPLE_BITS > MOM_W) ? SAMPLE_BITS : MOM_W) + 1);
    localparam int FLOOR_W     = 63;
    localparam int DECAY_W     = 16;
    localparam int CFG_IDX_W   = 8;

    localparam logic [DECAY_W-1:0] DECAY_RST = 16'd61604;
    localparam logic [FLOOR_W-1:0] FLOOR_RST = 63'd4951760157141521099;
    localparam logic signed [15:0] ONE_Q14   = 16'sd16384;

    localparam logic [CFG_IDX_W-1:0] CFG_DECAY = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR = 8'd1;

    localparam int PROD_SCALE = 2 * (SAMPLE_BITS - 1);
    localparam int NORM_SHR   = (PROD_SCALE > MOM_FRAC) ? PROD_SCALE - MOM_FRAC : 0;
    localparam int NORM_SHL   = (PROD_SCALE < MOM_FRAC) ? MOM_FRAC - PROD_SCALE : 0;
    localparam int NORM_XW    = PROD_W + MOM_W;

    // Brings a sample product to the moment scale, with floor on a right shift.
    function automatic logic signed [MOM_W-1:0] norm_prod(input logic signed [PROD_W-1:0] p);
        logic signed [NORM_XW-1:0] ext;
        logic signed [NORM_XW-1:0] sh;
        ext = NORM_XW'(p);
        sh  = (ext >>> NORM_SHR) <<< NORM_SHL;
        return sh[MOM_W-1:0];
    endfunction

endpackage

// ===== src/edc_smp_if.sv =====
// Channel interfaces for the sample pairs and the correlation results.
interface edc_smp_if import edc_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_a;
    logic signed [SAMPLE_BITS-1:0] sample_b;
    logic                          present_a;
    logic                          present_b;
    logic                          series_start;
    modport source (output valid, sample_a, sample_b, present_a, present_b, series_start,
                    input ready);
    modport sink   (input valid, sample_a, sample_b, present_a, present_b, series_start,
                    output ready);
endinterface

interface edc_cor_if ();
    logic               valid;
    logic               ready;
    logic signed [15:0] correlation;
    logic               correlation_valid;
    modport source (output valid, correlation, correlation_valid, input ready);
    modport sink   (input valid, correlation, correlation_valid, output ready);
endinterface

// ===== src/edc_blend.sv =====
// Bit-serial sample products followed by a bit-serial EWMA blend of the three moments.
module edc_blend import edc_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  logic signed [SAMPLE_BITS-1:0] i_y,
    input  logic [DECAY_W-1:0]            i_decay,
    input  logic signed [MOM_W-1:0]       i_old_aa,
    input  logic signed [MOM_W-1:0]       i_old_bb,
    input  logic signed [MOM_W-1:0]       i_old_ab,
    output logic signed [MOM_W-1:0]       o_new_aa,
    output logic signed [MOM_W-1:0]       o_new_bb,
    output logic signed [MOM_W-1:0]       o_new_ab,
    output logic                          o_done
);
    typedef enum logic [1:0] {B_IDLE, B_MUL, B_BLD} t_phase;

    t_phase                    r_phase;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_done;
    logic                      r_neg;
    logic [SAMPLE_BITS-1:0]    r_mx, r_my, r_ma, r_mb;
    logic [PROD_W-1:0]         r_pxx, r_pyy, r_pxy;
    logic [DECAY_W:0]          r_w, r_wc;
    logic signed [BLEND_W-1:0] r_saa, r_sbb, r_sab;

    logic [SAMPLE_BITS-1:0]    n_absx, n_absy;
    logic [SAMPLE_BITS:0]      n_hxx, n_hyy, n_hxy;
    logic signed [MOM_W-1:0]   n_qxx, n_qyy, n_qxy;
    logic signed [PROD_W-1:0]  n_sxy;

    assign n_absx = i_x[SAMPLE_BITS-1] ? (~i_x + 1'b1) : i_x;
    assign n_absy = i_y[SAMPLE_BITS-1] ? (~i_y + 1'b1) : i_y;

    // One multiplier bit per cycle is added into the top half, then everything shifts right.
    assign n_hxx = {1'b0, r_pxx[PROD_W-1:SAMPLE_BITS]} + (r_ma[0] ? {1'b0, r_mx} : '0);
    assign n_hyy = {1'b0, r_pyy[PROD_W-1:SAMPLE_BITS]} + (r_mb[0] ? {1'b0, r_my} : '0);
    assign n_hxy = {1'b0, r_pxy[PROD_W-1:SAMPLE_BITS]} + (r_mb[0] ? {1'b0, r_mx} : '0);

    assign n_sxy = r_neg ? -$signed(r_pxy) : $signed(r_pxy);
    assign n_qxx = norm_prod($signed(r_pxx));
    assign n_qyy = norm_prod($signed(r_pyy));
    assign n_qxy = norm_prod(n_sxy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= B_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_phase)
                B_IDLE: begin
                    if (i_start) begin
                        r_mx    <= n_absx;
                        r_my    <= n_absy;
                        r_ma    <= n_absx;
                        r_mb    <= n_absy;
                        r_neg   <= i_x[SAMPLE_BITS-1] ^ i_y[SAMPLE_BITS-1];
                        r_pxx   <= '0;
                        r_pyy   <= '0;
                        r_pxy   <= '0;
                        r_cnt   <= '0;
                        r_phase <= B_MUL;
                    end
                end
                B_MUL: begin
                    r_pxx <= {n_hxx, r_pxx[SAMPLE_BITS-1:1]};
                    r_pyy <= {n_hyy, r_pyy[SAMPLE_BITS-1:1]};
                    r_pxy <= {n_hxy, r_pxy[SAMPLE_BITS-1:1]};
                    r_ma  <= r_ma >> 1;
                    r_mb  <= r_mb >> 1;
                    if (r_cnt == CNT_W'(SAMPLE_BITS - 1)) begin
                        r_cnt   <= '0;
                        r_w     <= {1'b0, i_decay};
                        r_wc    <= (DECAY_W + 1)'(1 << DECAY_W) - {1'b0, i_decay};
                        r_saa   <= '0;
                        r_sbb   <= '0;
                        r_sab   <= '0;
                        r_phase <= B_BLD;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                B_BLD: begin
                    // Weight bits go most significant first, so the sum doubles each cycle.
                    r_saa <= (r_saa <<< 1) + (r_w[DECAY_W] ? BLEND_W'(i_old_aa) : '0)
                             + (r_wc[DECAY_W] ? BLEND_W'(n_qxx) : '0);
                    r_sbb <= (r_sbb <<< 1) + (r_w[DECAY_W] ? BLEND_W'(i_old_bb) : '0)
                             + (r_wc[DECAY_W] ? BLEND_W'(n_qyy) : '0);
                    r_sab <= (r_sab <<< 1) + (r_w[DECAY_W] ? BLEND_W'(i_old_ab) : '0)
                             + (r_wc[DECAY_W] ? BLEND_W'(n_qxy) : '0);
                    r_w   <= r_w << 1;
                    r_wc  <= r_wc << 1;
                    if (r_cnt == CNT_W'(DECAY_W)) begin
                        r_done  <= 1'b1;
                        r_phase <= B_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: r_phase <= B_IDLE;
            endcase
        end
    end

    assign o_new_aa = r_saa[MOM_W+DECAY_W-1:DECAY_W];
    assign o_new_bb = r_sbb[MOM_W+DECAY_W-1:DECAY_W];
    assign o_new_ab = r_sab[MOM_W+DECAY_W-1:DECAY_W];
    assign o_done   = r_done;
endmodule

// ===== src/edc_sqrt.sv =====
// Bit-serial product of the two variances, floor added, then a restoring integer square root.
module edc_sqrt import edc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [MOM_W-1:0]   i_var_a,
    input  logic [MOM_W-1:0]   i_var_b,
    input  logic [FLOOR_W-1:0] i_floor,
    output logic [ROOT_W-1:0]  o_root,
    output logic               o_done
);
    typedef enum logic [1:0] {S_IDLE, S_MUL, S_ROOT} t_phase;

    t_phase              r_phase;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_done;
    logic [MOM_W-1:0]    r_ma, r_mb;
    logic [2*MOM_W-1:0]  r_acc;
    logic [RAD_W-1:0]    r_rad;
    logic [ROOT_W+1:0]   r_rem;
    logic [ROOT_W-1:0]   r_root;

    logic [MOM_W:0]      n_hi;
    logic [ROOT_W+1:0]   n_sh, n_trial;

    assign n_hi    = {1'b0, r_acc[2*MOM_W-1:MOM_W]} + (r_mb[0] ? {1'b0, r_ma} : '0);
    assign n_sh    = {r_rem[ROOT_W-1:0], r_rad[RAD_W-1:RAD_W-2]};
    assign n_trial = {r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= S_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_phase)
                S_IDLE: begin
                    if (i_start) begin
                        r_ma    <= i_var_a;
                        r_mb    <= i_var_b;
                        r_acc   <= '0;
                        r_cnt   <= '0;
                        r_phase <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_acc <= {n_hi, r_acc[MOM_W-1:1]};
                    r_mb  <= r_mb >> 1;
                    if (r_cnt == CNT_W'(MOM_W - 1)) begin
                        r_cnt   <= '0;
                        r_phase <= S_ROOT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    r_rem  <= '0;
                    r_root <= '0;
                    // The product of two moments stays below the radicand width.
                    r_rad  <= RAD_W'({n_hi, r_acc[MOM_W-1:1]}) + RAD_W'(i_floor);
                end
                S_ROOT: begin
                    r_rad <= r_rad << 2;
                    if (n_sh >= n_trial) begin
                        r_rem  <= n_sh - n_trial;
                        r_root <= {r_root[ROOT_W-2:0], 1'b1};
                    end else begin
                        r_rem  <= n_sh;
                        r_root <= {r_root[ROOT_W-2:0], 1'b0};
                    end
                    if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                        r_done  <= 1'b1;
                        r_phase <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: r_phase <= S_IDLE;
            endcase
        end
    end

    assign o_root = r_root;
    assign o_done = r_done;
endmodule

// ===== src/edc_div.sv =====
// Restoring division of the scaled covariance by the root, with saturation to one.
module edc_div import edc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [MOM_W-1:0] i_cov,
    input  logic [ROOT_W-1:0]       i_den,
    output logic signed [15:0]      o_corr,
    output logic                    o_done
);
    typedef enum logic [1:0] {D_IDLE, D_RUN, D_END} t_phase;

    t_phase            r_phase;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_done;
    logic              r_neg;
    logic [ROOT_W-1:0] r_den, r_rem;
    logic [QUO_W-1:0]  r_low;
    logic [QUO_W-1:0]  r_quo;
    logic signed [15:0] r_corr;

    logic [MOM_W-1:0]  n_abs;
    logic [ROOT_W:0]   n_sh;
    logic [QUO_W-1:0]  n_sat;

    assign n_abs = i_cov[MOM_W-1] ? (~i_cov + 1'b1) : i_cov;
    assign n_sh  = {r_rem, r_low[QUO_W-1]};
    assign n_sat = (r_quo > QUO_W'(ONE_Q14)) ? QUO_W'(ONE_Q14) : r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= D_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_phase)
                D_IDLE: begin
                    if (i_start) begin
                        r_neg <= i_cov[MOM_W-1];
                        r_den <= i_den;
                        r_cnt <= '0;
                        r_quo <= '0;
                        // The dividend is the magnitude times 2^14; its top bits come first.
                        r_rem <= ROOT_W'(n_abs[ROOT_W-1:QUO_W-14]);
                        r_low <= {n_abs[QUO_W-15:0], 14'b0};
                        if (i_den == '0) begin
                            r_corr  <= '0;
                            r_done  <= 1'b1;
                        end else if (ROOT_W'(n_abs[ROOT_W-1:QUO_W-14]) >= i_den) begin
                            r_corr  <= i_cov[MOM_W-1] ? -ONE_Q14 : ONE_Q14;
                            r_done  <= 1'b1;
                        end else begin
                            r_phase <= D_RUN;
                        end
                    end
                end
                D_RUN: begin
                    r_low <= r_low << 1;
                    if (n_sh >= {1'b0, r_den}) begin
                        r_rem <= ROOT_W'(n_sh - {1'b0, r_den});
                        r_quo <= {r_quo[QUO_W-2:0], 1'b1};
                    end else begin
                        r_rem <= ROOT_W'(n_sh);
                        r_quo <= {r_quo[QUO_W-2:0], 1'b0};
                    end
                    if (r_cnt == CNT_W'(QUO_W - 1)) begin
                        r_phase <= D_END;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                D_END: begin
                    r_corr  <= r_neg ? -$signed({1'b0, n_sat[14:0]}) : $signed({1'b0, n_sat[14:0]});
                    r_done  <= 1'b1;
                    r_phase <= D_IDLE;
                end
                default: r_phase <= D_IDLE;
            endcase
        end
    end

    assign o_corr = r_corr;
    assign o_done = r_done;
endmodule

// ===== src/ewma_dynamic_correlation.sv =====
// Top level of the EWMA dynamic correlation block: moments, sequencing and result register.
// One sample pair is taken at a time. A series start or a pair with a missing value goes
// straight to the hold state and is answered from there. A full update runs from the
// transaction to the offered result through bit-serial sample products, a serial blend over
// the decay weight, a serial variance product, a square root at one result bit a cycle,
// division and hand-over between the stages. When the root is zero or the quotient is sure
// to saturate, division ends as soon as it starts, without its serial steps.
// The result register lets the next pair be taken while a result waits downstream.
module ewma_dynamic_correlation import edc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [FLOOR_W-1:0]   i_cfg_data,
    edc_smp_if.sink              i_smp,
    edc_cor_if.source            o_cor
);
    typedef enum logic [2:0] {T_IDLE, T_BLEND, T_ROOT, T_DIV, T_HOLD} t_state;

    t_state                        r_state;
    logic [DECAY_W-1:0]            r_decay;
    logic [FLOOR_W-1:0]            r_floor;
    logic signed [MOM_W-1:0]       r_aa, r_bb, r_ab;
    logic signed [SAMPLE_BITS-1:0] r_x, r_y;
    logic                          r_bst, r_sst, r_dst;
    logic signed [15:0]            r_pc;
    logic                          r_pv;
    logic                          r_ov;
    logic signed [15:0]            r_corr;
    logic                          r_cval;

    logic signed [MOM_W-1:0] n_aa, n_bb, n_ab;
    logic                    n_bdone, n_sdone, n_ddone;
    logic [ROOT_W-1:0]       n_root;
    logic signed [15:0]      n_corr;

    edc_blend u_blend (
        .i_clk, .i_rst_n, .i_start(r_bst), .i_x(r_x), .i_y(r_y), .i_decay(r_decay),
        .i_old_aa(r_aa), .i_old_bb(r_bb), .i_old_ab(r_ab),
        .o_new_aa(n_aa), .o_new_bb(n_bb), .o_new_ab(n_ab), .o_done(n_bdone)
    );

    edc_sqrt u_sqrt (
        .i_clk, .i_rst_n, .i_start(r_sst), .i_var_a(r_aa), .i_var_b(r_bb),
        .i_floor(r_floor), .o_root(n_root), .o_done(n_sdone)
    );

    edc_div u_div (
        .i_clk, .i_rst_n, .i_start(r_dst), .i_cov(r_ab), .i_den(n_root),
        .o_corr(n_corr), .o_done(n_ddone)
    );

    assign i_smp.ready           = (r_state == T_IDLE);
    assign o_cor.valid           = r_ov;
    assign o_cor.correlation     = r_corr;
    assign o_cor.correlation_valid = r_cval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            r_decay <= DECAY_RST;
            r_floor <= FLOOR_RST;
            r_aa    <= '0;
            r_bb    <= '0;
            r_ab    <= '0;
            r_bst   <= 1'b0;
            r_sst   <= 1'b0;
            r_dst   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_bst <= 1'b0;
            r_sst <= 1'b0;
            r_dst <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DECAY: r_decay <= i_cfg_data[DECAY_W-1:0];
                    CFG_FLOOR: r_floor <= i_cfg_data;
                    default: ;
                endcase
            end
            // In the hold state the result register is reloaded instead of emptied.
            if (r_ov && o_cor.ready && r_state != T_HOLD) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                T_IDLE: begin
                    if (i_smp.valid) begin
                        r_pc <= '0;
                        r_pv <= 1'b0;
                        if (i_smp.series_start) begin
                            r_aa    <= '0;
                            r_bb    <= '0;
                            r_ab    <= '0;
                            r_state <= T_HOLD;
                        end else if (!i_smp.present_a || !i_smp.present_b) begin
                            r_state <= T_HOLD;
                        end else begin
                            r_x     <= i_smp.sample_a;
                            r_y     <= i_smp.sample_b;
                            r_bst   <= 1'b1;
                            r_state <= T_BLEND;
                        end
                    end
                end
                T_BLEND: begin
                    if (n_bdone) begin
                        r_aa    <= n_aa;
                        r_bb    <= n_bb;
                        r_ab    <= n_ab;
                        r_sst   <= 1'b1;
                        r_state <= T_ROOT;
                    end
                end
                T_ROOT: begin
                    if (n_sdone) begin
                        r_dst   <= 1'b1;
                        r_state <= T_DIV;
                    end
                end
                T_DIV: begin
                    if (n_ddone) begin
                        r_pc    <= n_corr;
                        r_pv    <= 1'b1;
                        r_state <= T_HOLD;
                    end
                end
                T_HOLD: begin
                    if (!r_ov || o_cor.ready) begin
                        r_corr  <= r_pc;
                        r_cval  <= r_pv;
                        r_ov    <= 1'b1;
                        r_state <= T_IDLE;
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end
endmodule

// ===== src/edc_chk.sv =====
// Port-level checker for the EWMA correlation block and its bind to the top level.
module edc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_corr,
    input logic        i_cval
);
    // A result waiting downstream keeps its valid until the transaction completes.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn before it was taken");

    // Pairs are worked on one at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second pair taken while one is in progress");

    // An invalid result carries a zero correlation.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_cval |-> i_corr == 16'd0)
        else $error("invalid result with nonzero correlation");

    // The correlation never leaves the range of plus or minus one.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ($signed(i_corr) <= 16'sd16384) && ($signed(i_corr) >= -16'sd16384))
        else $error("correlation outside plus or minus one");
endmodule

bind ewma_dynamic_correlation edc_chk u_edc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_smp.valid),
    .i_in_ready  (i_smp.ready),
    .i_out_valid (o_cor.valid),
    .i_out_ready (o_cor.ready),
    .i_corr      (o_cor.correlation),
    .i_cval      (o_cor.correlation_valid)
);

// ===== tb/ewma_dynamic_correlation_tb.sv =====
// Self-checking testbench of the EWMA dynamic correlation block, with its own correlation predictor.
module ewma_dynamic_correlation_tb;
    import edc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 400;

    typedef struct packed {
        logic signed [15:0] correlation;
        logic               correlation_valid;
    } t_corr;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [FLOOR_W-1:0]   i_cfg_data;

    edc_smp_if smp_ch ();
    edc_cor_if cor_ch ();

    ewma_dynamic_correlation uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_smp       (smp_ch.sink),
        .o_cor       (cor_ch.source)
    );

    // Predictor state.
    logic [DECAY_W-1:0]     pred_decay;
    logic [FLOOR_W-1:0]     pred_floor;
    logic signed [MOM_W-1:0] mom_aa, mom_bb, mom_ab;

    t_corr corr_queue[$];
    int    mismatches;
    int    idle_cycles;
    int    send_idle_pct;
    int    stall_pct;
    bit    hold_off;
    bit    timed_out;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic signed [MOM_W-1:0] blend_moment(
        input logic signed [MOM_W-1:0] old_m, input logic signed [MOM_W-1:0] prod);
        logic signed [81:0] acc;
        acc = $signed({1'b0, pred_decay}) * old_m
            + $signed(18'd65536 - {2'b0, pred_decay}) * prod;
        return MOM_W'(acc >>> 16);
    endfunction

    function automatic logic signed [MOM_W-1:0] scaled_product(
        input logic signed [SAMPLE_BITS-1:0] x, input logic signed [SAMPLE_BITS-1:0] y);
        logic signed [95:0] p;
        p = 96'(x) * 96'(y);
        if (PROD_SCALE > MOM_FRAC)
            p = p >>> (PROD_SCALE - MOM_FRAC);
        else
            p = p <<< (MOM_FRAC - PROD_SCALE);
        return MOM_W'(p);
    endfunction

    function automatic t_corr predict_correlation(
        input logic signed [SAMPLE_BITS-1:0] a, input logic signed [SAMPLE_BITS-1:0] b,
        input logic pa, input logic pb, input logic start);
        t_corr r;
        logic [127:0] radicand;
        logic [127:0] cand;
        logic [63:0]  root;
        logic [63:0]  mag;
        logic [127:0] q;
        r = '0;
        if (start) begin
            mom_aa = '0;
            mom_bb = '0;
            mom_ab = '0;
            return r;
        end
        if (!pa || !pb)
            return r;
        mom_aa = blend_moment(mom_aa, scaled_product(a, a));
        mom_bb = blend_moment(mom_bb, scaled_product(b, b));
        mom_ab = blend_moment(mom_ab, scaled_product(a, b));
        radicand = 128'($unsigned(64'(mom_aa))) * 128'($unsigned(64'(mom_bb)))
                 + 128'(pred_floor);
        root = '0;
        for (int i = 63; i >= 0; i--) begin
            cand = 128'(root | (64'd1 << i));
            if (cand * cand <= radicand)
                root = root | (64'd1 << i);
        end
        r.correlation_valid = 1'b1;
        if (root != 0) begin
            mag = mom_ab < 0 ? 64'(-64'(mom_ab)) : 64'(mom_ab);
            q = (128'(mag) * 128'd16384) / 128'(root);
            if (q > 128'd16384)
                q = 128'd16384;
            r.correlation = mom_ab < 0 ? -16'(q) : 16'(q);
        end
        return r;
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [FLOOR_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_DECAY)
            pred_decay = val[DECAY_W-1:0];
        else if (idx == CFG_FLOOR)
            pred_floor = val;
    endtask

    // Drives one pair and waits until the transaction has been taken.
    // Valid is left as it is afterwards; the next call or the drain drives it.
    task automatic send_pair(input logic signed [SAMPLE_BITS-1:0] a,
                             input logic signed [SAMPLE_BITS-1:0] b,
                             input logic pa, input logic pb, input logic start);
        while ($urandom_range(99) < send_idle_pct) begin
            smp_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        smp_ch.valid        <= 1'b1;
        smp_ch.sample_a     <= a;
        smp_ch.sample_b     <= b;
        smp_ch.present_a    <= pa;
        smp_ch.present_b    <= pb;
        smp_ch.series_start <= start;
        do
            @(posedge i_clk);
        while (!smp_ch.ready);
        corr_queue = {corr_queue, predict_correlation(a, b, pa, pb, start)};
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        smp_ch.valid <= 1'b0;
        while (corr_queue.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Mostly well-formed series with random content, some missing values and restarts.
    task automatic random_pairs(input int count);
        logic signed [SAMPLE_BITS-1:0] a, b;
        int span;
        for (int n = 0; n < count; n++) begin
            span = $urandom_range(3);
            a = SAMPLE_BITS'($urandom);
            b = SAMPLE_BITS'($urandom);
            if (span == 0) begin
                a = a >>> $urandom_range(20);
            end else if (span == 1) begin
                b = ($urandom_range(1) != 0) ? a : -a;
            end
            send_pair(a, b, $urandom_range(15) != 0, $urandom_range(15) != 0,
                      $urandom_range(39) == 0);
        end
    endtask

    task automatic test_directed();
        logic signed [SAMPLE_BITS-1:0] mx, mn;
        mx = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        mn = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        send_pair(mx, mx, 1, 1, 0);
        send_pair(0, 0, 1, 1, 1);
        send_pair(0, 0, 1, 1, 0);
        send_pair(mn, mn, 1, 1, 0);
        send_pair(mn, mx, 1, 1, 0);
        send_pair(mx, mn, 1, 1, 0);
        send_pair(mx, 5, 0, 1, 0);
        send_pair(5, mx, 1, 0, 0);
        send_pair(1, -1, 0, 0, 0);
        send_pair(-1, -1, 1, 1, 0);
        send_pair(mx, mn, 0, 0, 1);
        send_pair(1, 1, 1, 1, 0);
        send_pair(12345, -54321, 1, 1, 0);
        send_pair(mn, 0, 1, 1, 0);
        wait_drained();
    endtask

    task automatic test_config_extremes();
        write_register(CFG_DECAY, '0);
        write_register(CFG_FLOOR, '0);
        send_pair(0, 0, 1, 1, 1);
        send_pair(0, 0, 1, 1, 0);
        send_pair(1000, -1000, 1, 1, 0);
        random_pairs(40);
        wait_drained();
        write_register(CFG_DECAY, 16'hFFFF);
        write_register(CFG_FLOOR, {FLOOR_W{1'b1}});
        random_pairs(40);
        wait_drained();
        write_register(CFG_DECAY, 16'd32768);
        write_register(CFG_FLOOR, 63'd1);
        random_pairs(40);
        wait_drained();
        write_register(CFG_DECAY, DECAY_RST);
        write_register(CFG_FLOOR, FLOOR_RST);
    endtask

    task automatic test_random_phases();
        send_idle_pct = 0;  stall_pct = 0;  random_pairs(350);
        send_idle_pct = 79; stall_pct = 0;  random_pairs(350);
        send_idle_pct = 0;  stall_pct = 79; random_pairs(350);
        send_idle_pct = 21; stall_pct = 21; random_pairs(350);
        wait_drained();
    endtask

    // The receiver holds off while pairs keep coming, so the block backs up.
    task automatic test_back_pressure();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off = 1'b1;
        random_pairs(6);
        wait_drained();
    endtask

    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                cor_ch.ready <= 1'b0;
                repeat (1500) @(negedge i_clk);
                hold_off = 1'b0;
            end
            cor_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && cor_ch.valid && cor_ch.ready) begin
            if (corr_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: correlation %0d valid %0b",
                             cor_ch.correlation, cor_ch.correlation_valid);
            end else begin
                t_corr want;
                want = corr_queue.pop_front();
                if (want.correlation !== cor_ch.correlation
                        || want.correlation_valid !== cor_ch.correlation_valid) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %0d/%0b, got %0d/%0b",
                                 want.correlation, want.correlation_valid,
                                 cor_ch.correlation, cor_ch.correlation_valid);
                end
            end
        end
    end

    // Counts cycles without any transaction on either channel.
    always @(posedge i_clk) begin
        if ((smp_ch.valid && smp_ch.ready) || (cor_ch.valid && cor_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        mismatches    = 0;
        idle_cycles   = 0;
        timed_out     = 1'b0;
        hold_off      = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        pred_decay    = DECAY_RST;
        pred_floor    = FLOOR_RST;
        mom_aa        = '0;
        mom_bb        = '0;
        mom_ab        = '0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        smp_ch.valid        = 1'b0;
        smp_ch.sample_a     = '0;
        smp_ch.sample_b     = '0;
        smp_ch.present_a    = 1'b0;
        smp_ch.present_b    = 1'b0;
        smp_ch.series_start = 1'b0;
        cor_ch.ready        = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_config_extremes();
        test_back_pressure();
        test_random_phases();
        if (mismatches == 0 && corr_queue.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
src/edc_pkg.sv
src/edc_smp_if.sv
src/edc_blend.sv
src/edc_sqrt.sv
src/edc_div.sv
src/ewma_dynamic_correlation.sv
src/edc_chk.sv
tb/ewma_dynamic_correlation_tb.sv
